/* rtl/core/scoped_shadow_checker_top_assert.svh */
// Assertion macros for the scoped shadow checker top level.
// Included by the top level; relies on the clock and reset in scope there.
`ifndef SCOPED_SHADOW_CHECKER_TOP_ASSERT_SVH
`define SCOPED_SHADOW_CHECKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scoped shadow checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scoped shadow checker assertion failed");

`endif

/* rtl/core/ssc_pkg.sv */
// Shared constants and types of the scoped shadow checker.
// No dependencies; imported by the top level.
package ssc_pkg;

   localparam int MAX_LEVELS  = 64;
   localparam int ENTRY_SLOTS = 256;
   localparam int KEY_BITS    = 32;

   localparam int LEVEL_BITS = $clog2(MAX_LEVELS);
   localparam int DEPTH_BITS = $clog2(MAX_LEVELS + 1);
   localparam int SLOT_BITS  = $clog2(ENTRY_SLOTS);
   localparam int SCAN_BITS  = $clog2(ENTRY_SLOTS + 1);

   // Event commands.
   localparam logic [1:0] CMD_ENTER   = 2'd0;
   localparam logic [1:0] CMD_EXIT    = 2'd1;
   localparam logic [1:0] CMD_DECLARE = 2'd2;

   // Diagnostic kinds.
   localparam logic [1:0] DIAG_NONE   = 2'd0;
   localparam logic [1:0] DIAG_REDECL = 2'd1;
   localparam logic [1:0] DIAG_SHADOW = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] REG_REPORT_LIMIT = 1'b0;

   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

   // One declaration table entry.
   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [LEVEL_BITS-1:0] level;
      logic [31:0]           origin;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

/* rtl/core/ssc_if.sv */
// Valid/ready channel interfaces for the scoped shadow checker events and results.
// Depends on nothing but plain logic types.
interface ssc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] scope_tag;
   logic [31:0] name_key;
   logic [31:0] origin_ref;
   logic [31:0] event_time;

   modport source (output valid, command, scope_tag, name_key, origin_ref, event_time,
                   input ready);
   modport sink   (input valid, command, scope_tag, name_key, origin_ref, event_time,
                   output ready);
endinterface

interface ssc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  diag_kind;
   logic        reported;
   logic [31:0] diag_time;
   logic [31:0] current_scope;
   logic [31:0] prior_scope;
   logic [31:0] diag_key;
   logic [31:0] new_origin;
   logic [31:0] prior_origin;
   logic [15:0] diag_total;
   logic        table_full;

   modport source (output valid, diag_kind, reported, diag_time, current_scope,
                   prior_scope, diag_key, new_origin, prior_origin, diag_total,
                   table_full, input ready);
   modport sink   (input valid, diag_kind, reported, diag_time, current_scope,
                   prior_scope, diag_key, new_origin, prior_origin, diag_total,
                   table_full, output ready);
endinterface

/* rtl/core/ssc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/core/scoped_shadow_checker_top.sv */
// Top level of the scoped shadow checker: sequencer, valid bits and CSR port.
// Depends on ssc_pkg, the ssc_req_if/ssc_rsp_if interfaces and ssc_ram.
//
// Usage: trace events arrive on req_chan (valid/ready); each accepted event
// produces exactly one result transfer on rsp_chan. Enter pushes a scope
// tag, exit pops a scope and clears its declarations, declare checks a key
// for redeclaration and shadowing and, unless it is redeclared or the table
// is full, records it in a 256-entry table. The report limit register is at
// CSR byte address 0 (APB style, pready always high); the user must make
// writes only while the block is idle, which the block does not enforce.
// An enter, an ignored event, an exit with no open scope or a declare at
// depth zero goes straight to the result. An exit or a declare scans the
// table, one stored entry read from the entry RAM and compared per cycle by
// a single comparator; an exit leaving a scope open then reads the new top
// scope tag, and a declare reads the prior scope tag if it has a diagnostic,
// then commits. One event is processed at a time; req ready is high only
// while idle. A finished result waits in the output register while rsp
// ready is low; the next event is still accepted, but its result waits until
// the output register frees. Reset clears the scope depth, the valid bits,
// the diagnostic counter and sets the report limit to 65535; no clearing pass.
`include "scoped_shadow_checker_top_assert.svh"

module scoped_shadow_checker_top
   import ssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ssc_req_if.sink      req_chan,
   ssc_rsp_if.source    rsp_chan,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_TAG_RD, S_TAG_WAIT, S_TOP_RD, S_TOP_WAIT, S_COMMIT, S_RESULT
   } state_type;

   state_type              state_ff;
   logic [1:0]             cmd_ff;
   logic [31:0]            key_ff;
   logic [31:0]            origin_ff;
   logic [31:0]            time_ff;
   logic [DEPTH_BITS-1:0]  depth_ff;
   logic [LEVEL_BITS-1:0]  cur_ff;
   logic [SCAN_BITS-1:0]   scan_ff;
   logic                   proc_ff;
   logic [SLOT_BITS-1:0]   proc_idx_ff;
   logic                   same_ff;
   logic                   outer_ff;
   logic [LEVEL_BITS-1:0]  best_ff;
   logic [31:0]            prior_origin_ff;
   logic                   free_found_ff;
   logic [SLOT_BITS-1:0]   free_slot_ff;
   logic [1:0]             kind_ff;
   logic                   rep_ff;
   logic                   full_ff;
   logic [31:0]            prior_scope_ff;
   logic [31:0]            cur_scope_ff;
   logic [15:0]            counter_ff;
   logic [15:0]            limit_ff;
   logic [ENTRY_SLOTS-1:0] valid_ff;
   logic                   rsp_valid_ff;

   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   csr_write;
   logic                   tag_we;
   logic [LEVEL_BITS-1:0]  tag_raddr_in;
   logic [31:0]            tag_rdata;
   logic                   ent_we;
   entry_type              ent_wdata;
   logic [ENTRY_BITS-1:0]  ent_rdata_raw;
   entry_type              ent_rdata;
   logic                   key_match;
   logic [DEPTH_BITS-1:0]  depth_dec;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign depth_dec = depth_ff - DEPTH_BITS'(1);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_REPORT_LIMIT) ? {16'd0, limit_ff} : 32'd0;

   // Scope tag memory: written on enter, read for the prior and current scope.
   assign tag_we = req_xfer && (req_chan.command == CMD_ENTER) &&
                   (depth_ff < DEPTH_BITS'(MAX_LEVELS));

   always_comb begin
      if (state_ff == S_TOP_RD) begin
         tag_raddr_in = depth_dec[LEVEL_BITS-1:0];
      end else if (same_ff) begin
         tag_raddr_in = cur_ff;
      end else begin
         tag_raddr_in = best_ff;
      end
   end

   ssc_ram #(
      .WIDTH (32),
      .DEPTH (MAX_LEVELS)
   ) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (depth_ff[LEVEL_BITS-1:0]),
      .wdata (req_chan.scope_tag),
      .raddr (tag_raddr_in),
      .rdata (tag_rdata)
   );

   // Declaration table memory: scanned one entry a cycle, written at commit.
   assign ent_we           = (state_ff == S_COMMIT) && !same_ff && free_found_ff;
   assign ent_wdata.key    = key_ff[KEY_BITS-1:0];
   assign ent_wdata.level  = cur_ff;
   assign ent_wdata.origin = origin_ff;
   assign ent_rdata        = entry_type'(ent_rdata_raw);

   ssc_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRY_SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (free_slot_ff),
      .wdata (ent_wdata),
      .raddr (scan_ff[SLOT_BITS-1:0]),
      .rdata (ent_rdata_raw)
   );

   // The shared comparator of the scan.
   assign key_match = (ent_rdata.key == key_ff[KEY_BITS-1:0]);

   // Sequencer, table state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         valid_ff     <= '0;
         counter_ff   <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         cur_scope_ff <= '0;
         proc_ff      <= 1'b0;
         same_ff      <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_REPORT_LIMIT)) begin
            limit_ff <= csr_pwdata[15:0];
         end
         if (rsp_xfer && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  cmd_ff        <= req_chan.command;
                  key_ff        <= req_chan.name_key;
                  origin_ff     <= req_chan.origin_ref;
                  time_ff       <= req_chan.event_time;
                  kind_ff       <= DIAG_NONE;
                  rep_ff        <= 1'b0;
                  full_ff       <= 1'b0;
                  scan_ff       <= '0;
                  proc_ff       <= 1'b0;
                  same_ff       <= 1'b0;
                  outer_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= S_RESULT;
                  case (req_chan.command)
                     CMD_ENTER: begin
                        if (tag_we) begin
                           depth_ff     <= depth_ff + DEPTH_BITS'(1);
                           cur_scope_ff <= req_chan.scope_tag;
                        end
                     end
                     CMD_EXIT: begin
                        if (depth_ff != '0) begin
                           depth_ff <= depth_dec;
                           state_ff <= S_SCAN;
                        end
                     end
                     CMD_DECLARE: begin
                        if (depth_ff != '0) begin
                           cur_ff   <= depth_dec[LEVEL_BITS-1:0];
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end

            S_SCAN: begin
               if (scan_ff != SCAN_BITS'(ENTRY_SLOTS)) begin
                  proc_ff     <= 1'b1;
                  proc_idx_ff <= scan_ff[SLOT_BITS-1:0];
                  scan_ff     <= scan_ff + SCAN_BITS'(1);
               end else begin
                  proc_ff <= 1'b0;
               end

               // Examine the entry read in the previous cycle.
               if (proc_ff) begin
                  if (cmd_ff == CMD_EXIT) begin
                     if (valid_ff[proc_idx_ff] &&
                         (ent_rdata.level == depth_ff[LEVEL_BITS-1:0])) begin
                        valid_ff[proc_idx_ff] <= 1'b0;
                     end
                  end else if (!valid_ff[proc_idx_ff]) begin
                     if (!free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_slot_ff  <= proc_idx_ff;
                     end
                  end else if (key_match) begin
                     if (ent_rdata.level == cur_ff) begin
                        if (!same_ff) begin
                           same_ff         <= 1'b1;
                           prior_origin_ff <= ent_rdata.origin;
                        end
                     end else if ((ent_rdata.level < cur_ff) && !same_ff) begin
                        if (!outer_ff || (ent_rdata.level > best_ff)) begin
                           outer_ff        <= 1'b1;
                           best_ff         <= ent_rdata.level;
                           prior_origin_ff <= ent_rdata.origin;
                        end
                     end
                  end
               end

               // Scan finished once the last read has been examined.
               if ((scan_ff == SCAN_BITS'(ENTRY_SLOTS)) && !proc_ff) begin
                  if (cmd_ff == CMD_EXIT) begin
                     if (depth_ff == '0) begin
                        cur_scope_ff <= '0;
                        state_ff     <= S_RESULT;
                     end else begin
                        state_ff <= S_TOP_RD;
                     end
                  end else if (same_ff || outer_ff) begin
                     state_ff <= S_TAG_RD;
                  end else begin
                     state_ff <= S_COMMIT;
                  end
               end
            end

            S_TAG_RD: begin
               state_ff <= S_TAG_WAIT;
            end

            S_TAG_WAIT: begin
               prior_scope_ff <= tag_rdata;
               state_ff       <= S_COMMIT;
            end

            S_TOP_RD: begin
               state_ff <= S_TOP_WAIT;
            end

            S_TOP_WAIT: begin
               cur_scope_ff <= tag_rdata;
               state_ff     <= S_RESULT;
            end

            S_COMMIT: begin
               if (same_ff) begin
                  kind_ff <= DIAG_REDECL;
               end else begin
                  kind_ff <= outer_ff ? DIAG_SHADOW : DIAG_NONE;
                  if (free_found_ff) begin
                     valid_ff[free_slot_ff] <= 1'b1;
                  end else begin
                     full_ff <= 1'b1;
                  end
               end
               if (same_ff || outer_ff) begin
                  rep_ff <= (counter_ff < limit_ff);
                  if (counter_ff != COUNT_MAX) begin
                     counter_ff <= counter_ff + 16'd1;
                  end
               end
               state_ff <= S_RESULT;
            end

            S_RESULT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result payload, loaded when the result enters the output register.
   always_ff @(posedge clock) begin
      if ((state_ff == S_RESULT) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_chan.diag_kind     <= kind_ff;
         rsp_chan.reported      <= rep_ff;
         rsp_chan.diag_time     <= (kind_ff != DIAG_NONE) ? time_ff : 32'd0;
         rsp_chan.current_scope <= cur_scope_ff;
         rsp_chan.prior_scope   <= (kind_ff != DIAG_NONE) ? prior_scope_ff : 32'd0;
         rsp_chan.diag_key      <= (kind_ff != DIAG_NONE) ? key_ff : 32'd0;
         rsp_chan.new_origin    <= (kind_ff != DIAG_NONE) ? origin_ff : 32'd0;
         rsp_chan.prior_origin  <= (kind_ff != DIAG_NONE) ? prior_origin_ff : 32'd0;
         rsp_chan.diag_total    <= counter_ff;
         rsp_chan.table_full    <= full_ff;
      end
   end

   // Assertions.
   `SSC_ASSERT_NEXT(a_busy_after_accept, req_xfer, !req_chan.ready)
   `SSC_ASSERT_NOW(a_depth_bounded, 1'b1, depth_ff <= DEPTH_BITS'(MAX_LEVELS))
   `SSC_ASSERT_NOW(a_kind_legal, rsp_valid_ff, rsp_chan.diag_kind <= DIAG_SHADOW)

endmodule
